FILE: sv/gal_pkg.sv
// Package for gravity_aspect_layout: widths, codes and beat types.
package gal_pkg;

  localparam int CoordBits = 20;
  localparam int SizeBits  = CoordBits - 1;
  localparam int DivBits   = 2 * SizeBits;
  localparam int WideBits  = DivBits + 3;

  typedef enum logic [1:0] {
    MODE_NONE        = 2'd0,
    MODE_FILL        = 2'd1,
    MODE_ASPECT_FILL = 2'd2,
    MODE_ASPECT_FIT  = 2'd3
  } scale_mode_t;

  typedef enum logic [1:0] {
    ALIGN_START  = 2'd0,
    ALIGN_CENTER = 2'd1,
    ALIGN_END    = 2'd2
  } align_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] box_left;
    logic signed [CoordBits-1:0] box_top;
    logic [SizeBits-1:0]         box_width;
    logic [SizeBits-1:0]         box_height;
    logic [SizeBits-1:0]         content_width;
    logic [SizeBits-1:0]         content_height;
    logic [1:0]                  scale_mode;
    logic [1:0]                  horiz_align;
    logic [1:0]                  vert_align;
  } in_beat_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_left;
    logic signed [CoordBits-1:0] out_top;
    logic [SizeBits-1:0]         out_width;
    logic [SizeBits-1:0]         out_height;
    logic [1:0]                  status;
  } out_beat_t;

  // sideband carried alongside the divider
  typedef struct packed {
    in_beat_t beat;
    logic     zero;
    logic     width_limits;
  } side_t;

endpackage

FILE: sv/gal_front.sv
// Front end: cross products, limiting side choice, divider operands.
module gal_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  gal_pkg::in_beat_t             in_data,
  output logic                          valid,
  output gal_pkg::side_t                side,
  output logic [gal_pkg::DivBits-1:0]   dividend,
  output logic [gal_pkg::SizeBits-1:0]  divisor
);
  import gal_pkg::*;

  logic                s1_valid;
  in_beat_t            s1_data;
  logic [DivBits-1:0]  wx;
  logic [DivBits-1:0]  hx;
  logic                zero;
  logic                wl;

  always_comb begin
    zero = (s1_data.content_width == '0) || (s1_data.content_height == '0);
    if (scale_mode_t'(s1_data.scale_mode) == MODE_ASPECT_FILL) begin
      wl = wx >= hx;
    end else begin
      wl = wx <= hx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      valid    <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_data           <= in_data;
      wx                <= DivBits'(in_data.box_width) * DivBits'(in_data.content_height);
      hx                <= DivBits'(in_data.box_height) * DivBits'(in_data.content_width);
      side.beat         <= s1_data;
      side.zero         <= zero;
      side.width_limits <= wl;
      dividend          <= wl ? wx : hx;
      divisor           <= wl ? s1_data.content_width : s1_data.content_height;
    end
  end

endmodule

FILE: sv/gal_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module gal_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  gal_pkg::side_t                side_in,
  input  logic [gal_pkg::DivBits-1:0]   dividend,
  input  logic [gal_pkg::SizeBits-1:0]  divisor,
  output logic                          valid,
  output gal_pkg::side_t                side_out,
  output logic [gal_pkg::DivBits-1:0]   quotient
);
  import gal_pkg::*;

  logic                vld [DivBits+1];
  side_t               sd  [DivBits+1];
  logic [DivBits-1:0]  num [DivBits+1];
  logic [DivBits-1:0]  quo [DivBits+1];
  logic [SizeBits:0]   rem [DivBits+1];
  logic [SizeBits-1:0] dvs [DivBits+1];

  assign vld[0] = in_valid;
  assign sd[0]  = side_in;
  assign num[0] = dividend;
  assign quo[0] = '0;
  assign rem[0] = '0;
  assign dvs[0] = divisor;

  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    logic [SizeBits:0] trial;
    logic              ge;
    assign trial = {rem[k][SizeBits-1:0], num[k][DivBits-1]};
    assign ge    = trial >= {1'b0, dvs[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1]  <= sd[k];
        dvs[k+1] <= dvs[k];
        num[k+1] <= {num[k][DivBits-2:0], 1'b0};
        quo[k+1] <= {quo[k][DivBits-2:0], ge};
        rem[k+1] <= ge ? trial - {1'b0, dvs[k]} : trial;
      end
    end
  end

  assign valid    = vld[DivBits];
  assign side_out = sd[DivBits];
  assign quotient = quo[DivBits];

endmodule

FILE: sv/gal_back.sv
// Back end: placement, alignment, saturation and status.
module gal_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  gal_pkg::side_t               side,
  input  logic [gal_pkg::DivBits-1:0]  quotient,
  output logic                         out_valid,
  output gal_pkg::out_beat_t           out_data
);
  import gal_pkg::*;

  localparam logic signed [WideBits-1:0] PosMax = WideBits'(2**(CoordBits-1) - 1);
  localparam logic signed [WideBits-1:0] PosMin = -PosMax - WideBits'(1);

  function automatic logic signed [WideBits-1:0] place(
    input logic signed [CoordBits-1:0] p,
    input logic [SizeBits-1:0]         b,
    input logic [DivBits-1:0]          s,
    input logic [1:0]                  code
  );
    logic signed [WideBits-1:0] pw;
    logic signed [WideBits-1:0] d;
    pw = {{(WideBits-CoordBits){p[CoordBits-1]}}, p};
    d  = $signed(WideBits'(b)) - $signed(WideBits'(s));
    unique case (align_t'(code))
      ALIGN_CENTER: place = pw + (d >>> 1);
      ALIGN_END:    place = pw + d;
      default:      place = pw;
    endcase
  endfunction

  logic                       b1_valid;
  logic signed [WideBits-1:0] b1_left;
  logic signed [WideBits-1:0] b1_top;
  logic [DivBits-1:0]         b1_width;
  logic [DivBits-1:0]         b1_height;
  logic                       b1_zero;

  logic signed [WideBits-1:0] ol, ot;
  logic [DivBits-1:0]         ow, oh;
  logic                       zst;
  in_beat_t                   bt;

  always_comb begin
    bt  = side.beat;
    ow  = DivBits'(bt.box_width);
    oh  = DivBits'(bt.box_height);
    ol  = place(bt.box_left, bt.box_width, ow, ALIGN_START);
    ot  = place(bt.box_top, bt.box_height, oh, ALIGN_START);
    zst = 1'b0;
    unique case (scale_mode_t'(bt.scale_mode))
      MODE_NONE: begin
        ow = DivBits'(bt.content_width);
        oh = DivBits'(bt.content_height);
        ol = place(bt.box_left, bt.box_width, ow, bt.horiz_align);
        ot = place(bt.box_top, bt.box_height, oh, bt.vert_align);
      end
      MODE_FILL: begin
      end
      MODE_ASPECT_FILL, MODE_ASPECT_FIT: begin
        if (side.zero) begin
          zst = 1'b1;
        end else begin
          if (side.width_limits) begin
            oh = quotient;
          end else begin
            ow = quotient;
          end
          ol = place(bt.box_left, bt.box_width, ow, ALIGN_CENTER);
          ot = place(bt.box_top, bt.box_height, oh, ALIGN_CENTER);
        end
      end
    endcase
  end

  logic l_hi, l_lo, t_hi, t_lo, w_hi, h_hi, sat;

  always_comb begin
    l_hi = b1_left > PosMax;
    l_lo = b1_left < PosMin;
    t_hi = b1_top > PosMax;
    t_lo = b1_top < PosMin;
    w_hi = |b1_width[DivBits-1:SizeBits];
    h_hi = |b1_height[DivBits-1:SizeBits];
    sat  = l_hi || l_lo || t_hi || t_lo || w_hi || h_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= in_valid;
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_left   <= ol;
      b1_top    <= ot;
      b1_width  <= ow;
      b1_height <= oh;
      b1_zero   <= zst;
      out_data.out_left   <= l_hi ? PosMax[CoordBits-1:0] :
                             l_lo ? PosMin[CoordBits-1:0] : b1_left[CoordBits-1:0];
      out_data.out_top    <= t_hi ? PosMax[CoordBits-1:0] :
                             t_lo ? PosMin[CoordBits-1:0] : b1_top[CoordBits-1:0];
      out_data.out_width  <= w_hi ? '1 : b1_width[SizeBits-1:0];
      out_data.out_height <= h_hi ? '1 : b1_height[SizeBits-1:0];
      out_data.status     <= b1_zero ? STATUS_ZERO : (sat ? STATUS_SAT : STATUS_OK);
    end
  end

endmodule

FILE: sv/gravity_aspect_layout.sv
// Top level of gravity_aspect_layout: aspect fit, fill and aligned placement.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or being taken. Depth is set by the bit-per-stage divider.
// Reset: synchronous, clears all stage valid bits; no other state.
module gravity_aspect_layout (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gal_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gal_pkg::out_beat_t  out_data
);
  import gal_pkg::*;

  logic               en;
  logic               f_valid;
  side_t              f_side;
  logic [DivBits-1:0] f_dividend;
  logic [SizeBits-1:0] f_divisor;
  logic               d_valid;
  side_t              d_side;
  logic [DivBits-1:0] d_quotient;

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  gal_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid && in_ready), .in_data(in_data),
    .valid(f_valid), .side(f_side), .dividend(f_dividend), .divisor(f_divisor)
  );

  gal_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_valid), .side_in(f_side), .dividend(f_dividend), .divisor(f_divisor),
    .valid(d_valid), .side_out(d_side), .quotient(d_quotient)
  );

  gal_back u_back (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d_valid), .side(d_side), .quotient(d_quotient),
    .out_valid(out_valid), .out_data(out_data)
  );

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready does not follow output stall");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status != 2'd3))
    else $error("bad status code");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

endmodule

FILE: sim/gravity_aspect_layout_tb.sv
// Testbench for gravity_aspect_layout: predicted placement checked beat by beat.
module gravity_aspect_layout_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gal_pkg::*;

  localparam longint PosMax  = (64'sd1 <<< (CoordBits - 1)) - 1;
  localparam longint PosMin  = -(64'sd1 <<< (CoordBits - 1));
  localparam longint SizeMax = (64'sd1 <<< SizeBits) - 1;
  localparam int     Latency = 2 + DivBits + 2;
  localparam int     InBits  = $bits(in_beat_t);

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  out_beat_t placements_due[$];
  int        errors = 0;
  int        hold_cycles = 0;
  int        hold_req = 0;
  int        hold_seen = 0;
  bit        stall_on = 1'b1;
  int        gap_max = 4;

  gravity_aspect_layout u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint floor_half(longint x);
    return x >>> 1;
  endfunction

  function automatic longint align_origin(longint p, longint b, longint s, logic [1:0] code);
    if (code == ALIGN_CENTER) begin
      return p + floor_half(b - s);
    end
    if (code == ALIGN_END) begin
      return p + b - s;
    end
    return p;
  endfunction

  function automatic out_beat_t place_rect(in_beat_t b);
    longint    bl, bt, bw, bh, cw, ch, ol, ot, ow, oh;
    bit        sat, wl;
    status_t   st;
    out_beat_t r;
    bl = b.box_left; bt = b.box_top;
    bw = b.box_width; bh = b.box_height;
    cw = b.content_width; ch = b.content_height;
    ol = bl; ot = bt; ow = bw; oh = bh;
    st = STATUS_OK; sat = 1'b0;
    if (b.scale_mode == MODE_NONE) begin
      ow = cw; oh = ch;
      ol = align_origin(bl, bw, cw, b.horiz_align);
      ot = align_origin(bt, bh, ch, b.vert_align);
    end else if (b.scale_mode != MODE_FILL) begin
      if (cw == 0 || ch == 0) begin
        st = STATUS_ZERO;
      end else begin
        wl = (b.scale_mode == MODE_ASPECT_FILL) ? (bw * ch >= bh * cw) : (bw * ch <= bh * cw);
        if (wl) begin
          oh = (ch * bw) / cw;
        end else begin
          ow = (cw * bh) / ch;
        end
        ol = bl + floor_half(bw - ow);
        ot = bt + floor_half(bh - oh);
      end
    end
    if (ol > PosMax) begin ol = PosMax; sat = 1'b1; end
    if (ol < PosMin) begin ol = PosMin; sat = 1'b1; end
    if (ot > PosMax) begin ot = PosMax; sat = 1'b1; end
    if (ot < PosMin) begin ot = PosMin; sat = 1'b1; end
    if (ow > SizeMax) begin ow = SizeMax; sat = 1'b1; end
    if (oh > SizeMax) begin oh = SizeMax; sat = 1'b1; end
    if (sat && st == STATUS_OK) begin
      st = STATUS_SAT;
    end
    r.out_left = ol[CoordBits-1:0];
    r.out_top = ot[CoordBits-1:0];
    r.out_width = ow[SizeBits-1:0];
    r.out_height = oh[SizeBits-1:0];
    r.status = st;
    return r;
  endfunction

  // one beat, with a random gap before it
  task automatic send_beat(in_beat_t b);
    int gap;
    gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    placements_due.push_back(place_rect(b));
  endtask

  task automatic idle_in();
    in_valid <= 1'b0;
  endtask

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b = InBits'({$urandom, $urandom, $urandom, $urandom});
    b.horiz_align = 2'($urandom_range(0, 3));
    b.vert_align = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: begin
        b.content_width = SizeBits'($urandom_range(0, 3));
        b.box_height = SizeBits'($urandom_range(0, 15));
      end
      1: begin
        b.box_left = $urandom_range(0, 1) ? CoordBits'(PosMax - $urandom_range(0, 40)) :
                                            CoordBits'(PosMin);
        b.box_top = $urandom_range(0, 1) ? CoordBits'(PosMin + $urandom_range(0, 40)) :
                                           CoordBits'(PosMax);
      end
      2: begin
        b.box_width = SizeBits'($urandom_range(0, 255));
        b.box_height = SizeBits'($urandom_range(0, 255));
        b.content_width = SizeBits'($urandom_range(1, 255));
        b.content_height = SizeBits'($urandom_range(1, 255));
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic test_directed();
    in_beat_t b;
    for (int m = 0; m < 4; m++) begin
      for (int a = 0; a < 4; a++) begin
        b = '0;
        b.box_left = CoordBits'(-100); b.box_top = CoordBits'(37);
        b.box_width = SizeBits'(640); b.box_height = SizeBits'(481);
        b.content_width = SizeBits'(1921); b.content_height = SizeBits'(1080);
        b.scale_mode = 2'(m); b.horiz_align = 2'(a); b.vert_align = 2'(3 - a);
        send_beat(b);
      end
    end
    b = '0; b.scale_mode = MODE_ASPECT_FIT; b.box_width = SizeBits'(100);
    b.content_height = SizeBits'(5);
    send_beat(b);
    b.scale_mode = MODE_ASPECT_FILL; b.content_width = SizeBits'(7); b.content_height = '0;
    send_beat(b);
    b = '1; b.box_left = CoordBits'(PosMax); b.box_top = CoordBits'(PosMin);
    b.scale_mode = MODE_NONE;
    b.horiz_align = ALIGN_END; b.vert_align = ALIGN_CENTER; b.content_width = '0;
    send_beat(b);
    b = '1; b.box_left = CoordBits'(PosMax); b.box_top = CoordBits'(PosMax);
    b.content_width = SizeBits'(1);
    b.scale_mode = MODE_ASPECT_FIT;
    send_beat(b);
    b.scale_mode = MODE_ASPECT_FILL;
    send_beat(b);
    b = '0; b.box_left = CoordBits'(PosMin); b.box_top = CoordBits'(PosMin);
    b.box_width = SizeBits'(SizeMax);
    b.content_width = SizeBits'(SizeMax); b.content_height = SizeBits'(SizeMax);
    b.scale_mode = MODE_NONE;
    b.horiz_align = ALIGN_CENTER; b.vert_align = ALIGN_END;
    send_beat(b);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 20) == 0) begin
        gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        stall_on = $urandom_range(0, 2) != 0;
      end
      send_beat(rand_beat());
    end
    idle_in();
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    hold_req++;
    for (int i = 0; i < 120; i++) begin
      send_beat(rand_beat());
    end
    gap_max = 4;
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 200;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stall_on || ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (placements_due.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data);
        errors++;
      end else begin
        e = placements_due.pop_front();
        if (out_data.out_left !== e.out_left) begin
          $display("%0t: out_left exp %0d got %0d", $time, e.out_left, out_data.out_left);
          errors++;
        end
        if (out_data.out_top !== e.out_top) begin
          $display("%0t: out_top exp %0d got %0d", $time, e.out_top, out_data.out_top);
          errors++;
        end
        if (out_data.out_width !== e.out_width) begin
          $display("%0t: out_width exp %0d got %0d", $time, e.out_width, out_data.out_width);
          errors++;
        end
        if (out_data.out_height !== e.out_height) begin
          $display("%0t: out_height exp %0d got %0d", $time, e.out_height,
                   out_data.out_height);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
          errors++;
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1210);
    wait_cycles = 0;
    while (placements_due.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0 && placements_due.size() == 0) begin
      $display("gravity_aspect_layout_tb: done, clean");
    end else begin
      $display("gravity_aspect_layout_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("gravity_aspect_layout_tb: done, errors");
    $finish;
  end

endmodule
